### rtl/nca_pkg.sv
// Shared constants, types and twiddle tables for the normalized cross ambiguity block.
package nca_pkg;

    localparam int DFT_LEN      = 64;
    localparam int SIGNAL_DEPTH = 4096;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int LIDX_W  = 12;
    localparam int SMP_W   = 16;
    localparam int PW      = 44;
    localparam int START_W = 13;
    localparam int BIN_W   = 6;
    localparam int QW      = 16;
    localparam int FLT_W   = 2;

    localparam int N_W     = $clog2(DFT_LEN);
    localparam int SA_W    = $clog2(SIGNAL_DEPTH);
    localparam int TW_FRAC = 15;
    localparam int TW_W    = TW_FRAC + 2;
    localparam int PROD_W  = 2 * SMP_W + 1;
    localparam int ACC_W   = PROD_W + TW_W + N_W + 1;
    localparam int MAG_W   = ACC_W - TW_FRAC;
    localparam int DEN_W   = 2 * PW;
    localparam int SQ_W    = 2 * MAG_W + 1;
    localparam int MUL_W   = (DEN_W > SQ_W) ? DEN_W : SQ_W;
    localparam int MPL_W   = (PW > MAG_W) ? PW : MAG_W;
    localparam int REM_W   = MUL_W + 1;
    localparam int CNT_W   = $clog2(DFT_LEN + MPL_W + QW);

    localparam logic [OP_W-1:0] OP_LOAD_CUTOUT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SIGNAL = 2'd1;
    localparam logic [OP_W-1:0] OP_SHIFT       = 2'd2;

    localparam logic [FLT_W-1:0] FAULT_NONE   = 2'd0;
    localparam logic [FLT_W-1:0] FAULT_WINDOW = 2'd1;
    localparam logic [FLT_W-1:0] FAULT_POWER  = 2'd2;

    localparam longint QUARTER_PI_Q30 = 64'sd843314857;
    localparam longint ONE_Q30        = 64'sd1073741824;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW_A,
        S_POW_B,
        S_POW_C,
        S_PROD,
        S_DEN,
        S_DFT,
        S_RND,
        S_MAG_R,
        S_MAG_I,
        S_DIV_INIT,
        S_DIV
    } t_state;

    typedef logic [DFT_LEN-1:0][TW_W-1:0] t_tw_tab;

    // exp(-j*2*pi*m/N) in Q1.15, from a Q30 series on one octant
    function automatic t_tw_tab build_tw(input bit want_sin);
        t_tw_tab tab;
        int      o;
        int      r;
        longint  x;
        longint  x2;
        longint  t;
        longint  ss;
        longint  cc;
        longint  sn;
        longint  cs;
        longint  v;
        for (int m = 0; m < DFT_LEN; m++) begin
            o = (8 * m) / DFT_LEN;
            r = 8 * m - o * DFT_LEN;
            if (o % 2 == 1) begin
                r = DFT_LEN - r;
            end
            x  = (QUARTER_PI_Q30 * longint'(r)) / DFT_LEN;
            x2 = (x * x) >>> 30;
            // sine: x - x^3/3! + x^5/5! ... five terms past the first
            t  = x;
            ss = x;
            t  = ((t * x2) >>> 30) / 64'sd6;
            ss = ss - t;
            t  = ((t * x2) >>> 30) / 64'sd20;
            ss = ss + t;
            t  = ((t * x2) >>> 30) / 64'sd42;
            ss = ss - t;
            t  = ((t * x2) >>> 30) / 64'sd72;
            ss = ss + t;
            t  = ((t * x2) >>> 30) / 64'sd110;
            ss = ss - t;
            // cosine: 1 - x^2/2! + x^4/4! ...
            t  = ONE_Q30;
            cc = ONE_Q30;
            t  = ((t * x2) >>> 30) / 64'sd2;
            cc = cc - t;
            t  = ((t * x2) >>> 30) / 64'sd12;
            cc = cc + t;
            t  = ((t * x2) >>> 30) / 64'sd30;
            cc = cc - t;
            t  = ((t * x2) >>> 30) / 64'sd56;
            cc = cc + t;
            t  = ((t * x2) >>> 30) / 64'sd90;
            cc = cc - t;
            case (o)
                0: begin sn = ss;  cs = cc;  end
                1: begin sn = cc;  cs = ss;  end
                2: begin sn = cc;  cs = -ss; end
                3: begin sn = ss;  cs = -cc; end
                4: begin sn = -ss; cs = -cc; end
                5: begin sn = -cc; cs = -ss; end
                6: begin sn = -cc; cs = ss;  end
                default: begin sn = -ss; cs = cc; end
            endcase
            v = want_sin ? sn : cs;
            v = (v + 64'sd16384) >>> 15;
            tab[m] = v[TW_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_COS = build_tw(1'b0);
    localparam t_tw_tab TW_SIN = build_tw(1'b1);

endpackage

### rtl/normalized_cross_ambiguity_top.sv
// Normalized cross ambiguity: stores, direct DFT on one MAC path, shared shift-add unit.
//
// Usage: every request is presented on the i_* fields with start high; it is taken
// at a clock edge where start is high and busy is low. Opcode 0 writes a cutout
// sample, opcode 1 a signal sample with its cumulative power; both give no result.
// Opcode 3 is taken and ignored. Opcode 2 computes one shift. cutout_power is
// written through i_cfg_we / i_cfg_wdata; the user must do so only while the block
// is idle, as the block itself does not enforce it. A shift request with a bad
// window returns one fault result on the next cycle. Otherwise S_POW_A, S_POW_B and
// S_POW_C fetch the window power (fault result if it or cutout_power is zero), then
// S_PROD forms the elementwise product and S_DEN the power product. Each bin then
// runs the complex MAC in S_DFT, rounding in S_RND, the shift-add squarer in S_MAG_R
// and S_MAG_I, and the divide in S_DIV_INIT and S_DIV. The serial shift-add and
// restoring-divide unit and the single MAC path set the time that a shift takes.
// Each result is shown for one cycle with o_result_valid; the receiver cannot stall,
// and busy stays high until the final bin (o_last_bin) is out.
// Reset clears the sequencer, the output strobe and cutout_power; the sample stores
// keep no reset and must be written before use.
module normalized_cross_ambiguity_top
    import nca_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [PW-1:0]            i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic [LIDX_W-1:0]        i_load_index,
    input  logic signed [SMP_W-1:0]  i_sample_real,
    input  logic signed [SMP_W-1:0]  i_sample_imag,
    input  logic [PW-1:0]            i_cumulative_power,
    input  logic [START_W-1:0]       i_shift_start,
    output logic                     o_result_valid,
    output logic [BIN_W-1:0]         o_bin_index,
    output logic [QW-1:0]            o_normalized_power,
    output logic                     o_last_bin,
    output logic [FLT_W-1:0]         o_fault
);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (TW_FRAC - 1);

    logic [2*SMP_W-1:0]  cut_mem [DFT_LEN];
    logic [2*SMP_W-1:0]  sig_mem [SIGNAL_DEPTH];
    logic [PW-1:0]       pow_mem [SIGNAL_DEPTH];
    logic [2*PROD_W-1:0] work_mem [DFT_LEN];

    t_state r_state, n_state;

    logic [PW-1:0]      r_cutout_power;
    logic [SA_W-1:0]    r_cs;
    logic [CNT_W-1:0]   r_cnt;
    logic [PW-1:0]      r_pow_q, r_pow_hi, r_wp;
    logic [2*SMP_W-1:0] r_cut_q, r_sig_q;
    logic [2*PROD_W-1:0] r_work_q;
    logic [N_W-1:0]     r_k, r_m, r_m_d1;
    logic signed [PROD_W+TW_W-1:0] r_prc, r_pis, r_pic, r_prs;
    logic signed [ACC_W-1:0] r_accr, r_acci;
    logic [MAG_W-1:0]   r_mi;
    logic [MUL_W-1:0]   r_acc, r_mcand, r_den;
    logic [MPL_W-1:0]   r_mplier;
    logic [REM_W-1:0]   r_rem;
    logic [QW-1:0]      r_q;
    logic               r_sat;

    logic               r_out_vld;
    logic [BIN_W-1:0]   r_out_bin;
    logic [QW-1:0]      r_out_pow;
    logic               r_out_last;
    logic [FLT_W-1:0]   r_out_fault;

    logic               accept, shift_req, win_bad, power_bad, div_ge, last_k;
    logic [PW-1:0]      wp;
    logic [SA_W-1:0]    pow_raddr, sig_raddr;
    logic [N_W-1:0]     cut_raddr;
    logic [START_W+1:0] win_end;
    logic [MUL_W-1:0]   acc_sum;
    logic [REM_W:0]     rem2;
    logic [QW-1:0]      q_final;
    logic signed [SMP_W-1:0]  ar, ai, br, bi;
    logic signed [PROD_W-1:0] p_re, p_im, wr, wi;
    logic signed [TW_W-1:0]   tw_c, tw_s;
    logic signed [ACC_W-1:0]  rnd_r, rnd_i;
    logic [ACC_W-1:0]   mag_r, mag_i;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign shift_req = accept && (i_opcode == OP_SHIFT);
    assign win_end   = (START_W+2)'(i_shift_start) + (START_W+2)'(DFT_LEN - 1);
    assign win_bad   = (i_shift_start == '0) || (int'(win_end) > SIGNAL_DEPTH);

    // window power: first window uses the cumulative power directly
    always_comb begin
        if (r_cs == '0) begin
            wp = r_pow_hi;
        end else if (r_pow_hi > r_pow_q) begin
            wp = r_pow_hi - r_pow_q;
        end else begin
            wp = '0;
        end
    end
    assign power_bad = (wp == '0) || (r_cutout_power == '0);

    assign pow_raddr = (r_state == S_POW_B) ? r_cs - SA_W'(1)
                                            : r_cs + SA_W'(DFT_LEN - 1);
    assign cut_raddr = r_cnt[N_W-1:0];
    assign sig_raddr = r_cs + SA_W'(r_cnt);

    assign ar = signed'(r_cut_q[2*SMP_W-1:SMP_W]);
    assign ai = signed'(r_cut_q[SMP_W-1:0]);
    assign br = signed'(r_sig_q[2*SMP_W-1:SMP_W]);
    assign bi = signed'(r_sig_q[SMP_W-1:0]);
    assign p_re = PROD_W'(ar * br) - PROD_W'(ai * bi);
    assign p_im = PROD_W'(ar * bi) + PROD_W'(ai * br);

    assign wr   = signed'(r_work_q[2*PROD_W-1:PROD_W]);
    assign wi   = signed'(r_work_q[PROD_W-1:0]);
    assign tw_c = signed'(TW_COS[r_m_d1]);
    assign tw_s = signed'(TW_SIN[r_m_d1]);

    assign rnd_r = (r_accr + RND_HALF) >>> TW_FRAC;
    assign rnd_i = (r_acci + RND_HALF) >>> TW_FRAC;
    assign mag_r = rnd_r[ACC_W-1] ? ACC_W'(-rnd_r) : ACC_W'(rnd_r);
    assign mag_i = rnd_i[ACC_W-1] ? ACC_W'(-rnd_i) : ACC_W'(rnd_i);

    // shared shift-add unit
    assign acc_sum = r_acc + (r_mplier[0] ? r_mcand : '0);

    // restoring divide step; quotient stays below 2^QW when not saturated
    assign rem2    = {r_rem, 1'b0};
    assign div_ge  = (rem2 >= (REM_W+1)'(r_den));
    assign q_final = {r_q[QW-2:0], div_ge};
    assign last_k  = (r_k == N_W'(DFT_LEN - 1));

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_LOAD_CUTOUT) && (int'(i_load_index) < DFT_LEN)) begin
            cut_mem[i_load_index[N_W-1:0]] <= {i_sample_real, i_sample_imag};
        end
        if (accept && (i_opcode == OP_LOAD_SIGNAL) && (int'(i_load_index) < SIGNAL_DEPTH)) begin
            sig_mem[i_load_index[SA_W-1:0]] <= {i_sample_real, i_sample_imag};
            pow_mem[i_load_index[SA_W-1:0]] <= i_cumulative_power;
        end
        if ((r_state == S_PROD) && (r_cnt != '0)) begin
            work_mem[N_W'(r_cnt - CNT_W'(1))] <= {p_re, p_im};
        end
        r_cut_q  <= cut_mem[cut_raddr];
        r_sig_q  <= sig_mem[sig_raddr];
        r_pow_q  <= pow_mem[pow_raddr];
        r_work_q <= work_mem[r_cnt[N_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cutout_power <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cutout_power <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (shift_req && !win_bad) begin
                    n_state = S_POW_A;
                end
            end
            S_POW_A: n_state = S_POW_B;
            S_POW_B: n_state = S_POW_C;
            S_POW_C: n_state = power_bad ? S_IDLE : S_PROD;
            S_PROD: begin
                if (r_cnt == CNT_W'(DFT_LEN)) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                if (r_cnt == CNT_W'(MPL_W - 1)) begin
                    n_state = S_DFT;
                end
            end
            S_DFT: begin
                if (r_cnt == CNT_W'(DFT_LEN + 1)) begin
                    n_state = S_RND;
                end
            end
            S_RND: n_state = S_MAG_R;
            S_MAG_R: begin
                if (r_cnt == CNT_W'(MPL_W - 1)) begin
                    n_state = S_MAG_I;
                end
            end
            S_MAG_I: begin
                if (r_cnt == CNT_W'(MPL_W - 1)) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = last_k ? S_IDLE : S_DFT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath under the sequencer
    always_ff @(posedge i_clk) begin
        r_m_d1 <= r_m;
        r_m    <= r_m + r_k;
        r_prc  <= wr * tw_c;
        r_pis  <= wi * tw_s;
        r_pic  <= wi * tw_c;
        r_prs  <= wr * tw_s;
        r_cnt  <= r_cnt + CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                r_cs  <= SA_W'(i_shift_start - START_W'(1));
                r_cnt <= '0;
            end
            S_POW_B: r_pow_hi <= r_pow_q;
            S_POW_C: begin
                r_wp  <= wp;
                r_cnt <= '0;
            end
            S_PROD: begin
                if (r_cnt == CNT_W'(DFT_LEN)) begin
                    r_cnt    <= '0;
                    r_acc    <= '0;
                    r_mcand  <= MUL_W'(r_cutout_power);
                    r_mplier <= MPL_W'(r_wp);
                end
            end
            S_DEN, S_MAG_R, S_MAG_I: begin
                r_acc    <= acc_sum;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (r_cnt == CNT_W'(MPL_W - 1)) begin
                    r_cnt <= '0;
                    if (r_state == S_DEN) begin
                        r_den  <= acc_sum;
                        r_acc  <= '0;
                        r_k    <= '0;
                        r_m    <= '0;
                        r_accr <= '0;
                        r_acci <= '0;
                    end else if (r_state == S_MAG_R) begin
                        r_mcand  <= MUL_W'(r_mi);
                        r_mplier <= MPL_W'(r_mi);
                    end
                end
            end
            S_DFT: begin
                if (r_cnt >= CNT_W'(2)) begin
                    r_accr <= r_accr + ACC_W'(r_prc) + ACC_W'(r_pis);
                    r_acci <= r_acci + ACC_W'(r_pic) - ACC_W'(r_prs);
                end
            end
            S_RND: begin
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= MUL_W'(mag_r[MAG_W-1:0]);
                r_mplier <= MPL_W'(mag_r[MAG_W-1:0]);
                r_mi     <= mag_i[MAG_W-1:0];
            end
            S_DIV_INIT: begin
                r_sat <= (r_acc >= r_den);
                r_rem <= REM_W'(r_acc);
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? REM_W'(rem2 - (REM_W+1)'(r_den)) : REM_W'(rem2);
                r_q   <= q_final;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_cnt  <= '0;
                    r_k    <= r_k + N_W'(1);
                    r_m    <= '0;
                    r_accr <= '0;
                    r_acci <= '0;
                end
            end
            default: ;
        endcase
    end

    // result register, one cycle per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (shift_req && win_bad) begin
                r_out_vld <= 1'b1;
            end else if ((r_state == S_POW_C) && power_bad) begin
                r_out_vld <= 1'b1;
            end else if ((r_state == S_DIV) && (r_cnt == CNT_W'(QW - 1))) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_req && win_bad) begin
            r_out_bin   <= '0;
            r_out_pow   <= '0;
            r_out_last  <= 1'b1;
            r_out_fault <= FAULT_WINDOW;
        end else if ((r_state == S_POW_C) && power_bad) begin
            r_out_bin   <= '0;
            r_out_pow   <= '0;
            r_out_last  <= 1'b1;
            r_out_fault <= FAULT_POWER;
        end else if ((r_state == S_DIV) && (r_cnt == CNT_W'(QW - 1))) begin
            r_out_bin   <= BIN_W'(r_k);
            r_out_pow   <= r_sat ? '1 : q_final;
            r_out_last  <= last_k;
            r_out_fault <= FAULT_NONE;
        end
    end

    assign o_result_valid     = r_out_vld;
    assign o_bin_index        = r_out_bin;
    assign o_normalized_power = r_out_pow;
    assign o_last_bin         = r_out_last;
    assign o_fault            = r_out_fault;

    a_shift_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift_req && !win_bad) |=> busy)
        else $error("shift request did not start the sequencer");

    a_fault_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_fault != FAULT_NONE)) |-> (o_last_bin && (o_normalized_power == '0)))
        else $error("fault result not a lone final result");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_bin) |-> !busy)
        else $error("sequencer still busy after final result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && busy) |=> !o_result_valid)
        else $error("back to back results within one shift");

endmodule

### verif/tb_top.sv
// Testbench for normalized_cross_ambiguity_top: loads, shift requests, per-bin checking.
module tb_top;
    import nca_pkg::*;

    // signal store entries that the stimulus fills; windows start in 1..SIG_FILL-DFT_LEN+1
    localparam int SIG_FILL = 68;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [QW-1:0]    npow;
        logic             last;
        logic [FLT_W-1:0] flt;
    } t_bin_result;

    // Mirrors the block's stores and predicts the bins of each shift request
    class ambiguity_scoreboard;
        t_bin_result      pending_bins[$];
        shortint          cut_re[DFT_LEN];
        shortint          cut_im[DFT_LEN];
        shortint          sig_re[SIGNAL_DEPTH];
        shortint          sig_im[SIGNAL_DEPTH];
        logic [PW-1:0]    pow_mem[SIGNAL_DEPTH];
        logic [PW-1:0]    cut_power;
        longint           tw_c[DFT_LEN];
        longint           tw_s[DFT_LEN];
        int               errors;
        int               shifts;
        int               faults;
        int               bins_seen;

        function new();
            longint x;
            longint x2;
            longint t;
            longint ss;
            longint cc;
            longint sn;
            longint cv;
            int     o;
            int     r;
            errors = 0;
            shifts = 0;
            faults = 0;
            bins_seen = 0;
            cut_power = '0;
            for (int m = 0; m < DFT_LEN; m++) begin
                o = (8 * m) / DFT_LEN;
                r = 8 * m - o * DFT_LEN;
                if (o % 2 == 1) r = DFT_LEN - r;
                x  = (QUARTER_PI_Q30 * r) / DFT_LEN;
                x2 = (x * x) >> 30;
                t  = x;
                ss = x;
                for (int i = 1; i <= 5; i++) begin
                    t  = ((t * x2) >> 30) / ((2 * i) * (2 * i + 1));
                    ss = (i % 2 == 1) ? ss - t : ss + t;
                end
                t  = ONE_Q30;
                cc = ONE_Q30;
                for (int i = 1; i <= 5; i++) begin
                    t  = ((t * x2) >> 30) / ((2 * i - 1) * (2 * i));
                    cc = (i % 2 == 1) ? cc - t : cc + t;
                end
                case (o)
                    0: begin sn = ss;  cv = cc;  end
                    1: begin sn = cc;  cv = ss;  end
                    2: begin sn = cc;  cv = -ss; end
                    3: begin sn = ss;  cv = -cc; end
                    4: begin sn = -ss; cv = -cc; end
                    5: begin sn = -cc; cv = -ss; end
                    6: begin sn = -cc; cv = ss;  end
                    default: begin sn = -ss; cv = cc; end
                endcase
                tw_s[m] = (sn + 16384) >>> 15;
                tw_c[m] = (cv + 16384) >>> 15;
            end
        endfunction

        function void push_fault(logic [FLT_W-1:0] code);
            t_bin_result e;
            e.bin  = '0;
            e.npow = '0;
            e.last = 1'b1;
            e.flt  = code;
            pending_bins.push_back(e);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [LIDX_W-1:0] idx,
                                   logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im,
                                   logic [PW-1:0] cpow, logic [START_W-1:0] st);
            int            cs;
            logic [PW-1:0] wp;
            longint        pr[DFT_LEN];
            longint        pim[DFT_LEN];
            longint        accr;
            longint        acci;
            longint        xr;
            longint        xi;
            logic [127:0]  mr;
            logic [127:0]  mi;
            logic [127:0]  num;
            logic [127:0]  den;
            t_bin_result   e;
            if (op == OP_LOAD_CUTOUT) begin
                if (idx < DFT_LEN) begin
                    cut_re[idx] = re;
                    cut_im[idx] = im;
                end
                return;
            end
            if (op == OP_LOAD_SIGNAL) begin
                sig_re[idx]  = re;
                sig_im[idx]  = im;
                pow_mem[idx] = cpow;
                return;
            end
            if (op != OP_SHIFT) return;
            shifts++;
            if (st == 0 || int'(st) - 1 + DFT_LEN > SIGNAL_DEPTH) begin
                push_fault(FAULT_WINDOW);
                return;
            end
            cs = int'(st) - 1;
            if (cs == 0) wp = pow_mem[DFT_LEN-1];
            else if (pow_mem[cs+DFT_LEN-1] > pow_mem[cs-1])
                wp = pow_mem[cs+DFT_LEN-1] - pow_mem[cs-1];
            else wp = '0;
            if (wp == 0 || cut_power == 0) begin
                push_fault(FAULT_POWER);
                return;
            end
            for (int n = 0; n < DFT_LEN; n++) begin
                pr[n]  = longint'(cut_re[n]) * sig_re[cs+n] - longint'(cut_im[n]) * sig_im[cs+n];
                pim[n] = longint'(cut_re[n]) * sig_im[cs+n] + longint'(cut_im[n]) * sig_re[cs+n];
            end
            den = 128'(cut_power) * 128'(wp);
            for (int k = 0; k < DFT_LEN; k++) begin
                accr = 0;
                acci = 0;
                for (int n = 0; n < DFT_LEN; n++) begin
                    accr += pr[n] * tw_c[(k*n) % DFT_LEN] + pim[n] * tw_s[(k*n) % DFT_LEN];
                    acci += pim[n] * tw_c[(k*n) % DFT_LEN] - pr[n] * tw_s[(k*n) % DFT_LEN];
                end
                xr = (accr + 16384) >>> 15;
                xi = (acci + 16384) >>> 15;
                mr = 128'(xr < 0 ? -xr : xr);
                mi = 128'(xi < 0 ? -xi : xi);
                num = (mr * mr + mi * mi) << 16;
                e.bin  = k[BIN_W-1:0];
                e.npow = (num >= (den << 16)) ? 16'hFFFF : QW'(num / den);
                e.last = (k == DFT_LEN - 1);
                e.flt  = FAULT_NONE;
                pending_bins.push_back(e);
            end
        endfunction

        function void check_result(t_bin_result got);
            t_bin_result e;
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected result bin=%0d npow=%0d last=%0b fault=%0d",
                         $time, got.bin, got.npow, got.last, got.flt);
                errors++;
                return;
            end
            e = pending_bins.pop_front();
            bins_seen++;
            if (got.flt != FAULT_NONE) faults++;
            if (got.bin !== e.bin || got.npow !== e.npow || got.last !== e.last ||
                got.flt !== e.flt) begin
                $display("%0t: mismatch expected bin=%0d npow=%0d last=%0b fault=%0d",
                         $time, e.bin, e.npow, e.last, e.flt);
                $display("%0t:          actual   bin=%0d npow=%0d last=%0b fault=%0d",
                         $time, got.bin, got.npow, got.last, got.flt);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [PW-1:0]           i_cfg_wdata;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_opcode;
    logic [LIDX_W-1:0]       i_load_index;
    logic signed [SMP_W-1:0] i_sample_real;
    logic signed [SMP_W-1:0] i_sample_imag;
    logic [PW-1:0]           i_cumulative_power;
    logic [START_W-1:0]      i_shift_start;
    logic                    o_result_valid;
    logic [BIN_W-1:0]        o_bin_index;
    logic [QW-1:0]           o_normalized_power;
    logic                    o_last_bin;
    logic [FLT_W-1:0]        o_fault;

    ambiguity_scoreboard sb;
    int                  idle_cycles;
    t_bin_result         got;

    normalized_cross_ambiguity_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_load_index       (i_load_index),
        .i_sample_real      (i_sample_real),
        .i_sample_imag      (i_sample_imag),
        .i_cumulative_power (i_cumulative_power),
        .i_shift_start      (i_shift_start),
        .o_result_valid     (o_result_valid),
        .o_bin_index        (o_bin_index),
        .o_normalized_power (o_normalized_power),
        .o_last_bin         (o_last_bin),
        .o_fault            (o_fault)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // requests taken and bins returned, sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request(i_opcode, i_load_index, i_sample_real, i_sample_imag,
                            i_cumulative_power, i_shift_start);
        if (i_rst_n && o_result_valid) begin
            got.bin  = o_bin_index;
            got.npow = o_normalized_power;
            got.last = o_last_bin;
            got.flt  = o_fault;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(logic [OP_W-1:0] op, logic [LIDX_W-1:0] idx, logic [SMP_W-1:0] re,
                        logic [SMP_W-1:0] im, logic [PW-1:0] cpow, logic [START_W-1:0] st,
                        bit gaps);
        int g;
        start              <= 1'b1;
        i_opcode           <= op;
        i_load_index       <= idx;
        i_sample_real      <= re;
        i_sample_imag      <= im;
        i_cumulative_power <= cpow;
        i_shift_start      <= st;
        do @(posedge i_clk); while (busy);
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic shift_at(logic [START_W-1:0] st);
        send(OP_SHIFT, LIDX_W'($urandom), SMP_W'($urandom), SMP_W'($urandom),
             PW'({$urandom, $urandom}), st, 1'b1);
    endtask

    // wait out every pending bin, then write cutout_power
    task automatic set_cutout_power(logic [PW-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bins.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.cut_power = v;
    endtask

    task automatic load_signal_range(int lo, int hi, logic [PW-1:0] base);
        logic [PW-1:0] p;
        p = base;
        for (int i = lo; i <= hi; i++) begin
            p = p + PW'($urandom_range(1, 1 << 30));
            send(OP_LOAD_SIGNAL, LIDX_W'(i), SMP_W'($urandom), SMP_W'($urandom), p,
                 START_W'($urandom), 1'b0);
        end
    endtask

    initial begin
        int r;
        int idx;
        sb = new();
        idle_cycles        = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        start              = 1'b0;
        i_opcode           = OP_LOAD_CUTOUT;
        i_load_index       = '0;
        i_sample_real      = '0;
        i_sample_imag      = '0;
        i_cumulative_power = '0;
        i_shift_start      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_cutout_power('0);
        // fill the cutout with extremes up front, then the low signal region
        send(OP_LOAD_CUTOUT, LIDX_W'(0), 16'h8000, 16'h8000, '0, '0, 1'b0);
        send(OP_LOAD_CUTOUT, LIDX_W'(1), 16'h7FFF, 16'h7FFF, '0, '0, 1'b0);
        for (int i = 2; i < DFT_LEN; i++)
            send(OP_LOAD_CUTOUT, LIDX_W'(i), SMP_W'($urandom), SMP_W'($urandom), '0, '0, 1'b0);
        send(OP_LOAD_CUTOUT, 12'hFFF, 16'h1234, 16'h4321, '0, '0, 1'b1);
        send(OP_LOAD_CUTOUT, LIDX_W'(DFT_LEN), 16'h0, 16'h0, '0, '0, 1'b1);
        load_signal_range(0, SIG_FILL - 1, '0);
        send(OP_LOAD_SIGNAL, LIDX_W'(5), 16'h8000, 16'h7FFF, sb.pow_mem[5], '0, 1'b1);
        send(OP_RESERVED, 12'hFFF, 16'hFFFF, 16'hFFFF, '1, '1, 1'b1);

        // zero cutout power, then windows off either end
        shift_at(START_W'(1));
        shift_at(START_W'(0));
        shift_at(START_W'(SIGNAL_DEPTH - DFT_LEN + 2));
        shift_at(13'h1FFF);
        set_cutout_power('1);
        shift_at(START_W'(1));
        shift_at(START_W'(SIG_FILL - DFT_LEN + 1));
        set_cutout_power(44'd1);
        shift_at(START_W'(2));
        // window start one with zero power at its end
        send(OP_LOAD_SIGNAL, LIDX_W'(DFT_LEN - 1), SMP_W'($urandom), SMP_W'($urandom),
             '0, '0, 1'b1);
        shift_at(START_W'(1));
        // equal cumulative powers at both ends of the window
        send(OP_LOAD_SIGNAL, LIDX_W'(DFT_LEN), SMP_W'($urandom), SMP_W'($urandom),
             sb.pow_mem[0], '0, 1'b1);
        shift_at(START_W'(2));
        load_signal_range(DFT_LEN - 1, DFT_LEN, sb.pow_mem[DFT_LEN-2]);

        for (int ph = 0; ph < 3; ph++) begin
            r = $urandom_range(0, 3);
            set_cutout_power(r == 0 ? PW'($urandom_range(1, 1001)) :
                             r == 1 ? PW'({$urandom, $urandom}) :
                             PW'(64'd1 << $urandom_range(20, 43)));
            for (int n = 0; n < 8; n++) begin
                r = $urandom_range(0, 19);
                if (r < 9) begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        shift_at($urandom_range(0, 1) ? START_W'(0) :
                                 START_W'($urandom_range(SIGNAL_DEPTH - DFT_LEN + 2, 8191)));
                    else
                        shift_at(START_W'($urandom_range(1, SIG_FILL - DFT_LEN + 1)));
                end else if (r < 16) begin
                    idx = $urandom_range(0, SIG_FILL - 1);
                    send(OP_LOAD_SIGNAL, LIDX_W'(idx), SMP_W'($urandom), SMP_W'($urandom),
                         ($urandom_range(0, 7) == 0) ? PW'({$urandom, $urandom}) : sb.pow_mem[idx],
                         START_W'($urandom), 1'b1);
                end else if (r < 19) begin
                    send(OP_LOAD_CUTOUT, LIDX_W'($urandom_range(0, 127)), SMP_W'($urandom),
                         SMP_W'($urandom), PW'({$urandom, $urandom}), START_W'($urandom), 1'b1);
                end else begin
                    send(OP_RESERVED, LIDX_W'($urandom), SMP_W'($urandom), SMP_W'($urandom),
                         PW'({$urandom, $urandom}), START_W'($urandom), 1'b1);
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bins.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d shift requests, %0d bins checked, %0d fault results.",
                 sb.shifts, sb.bins_seen, sb.faults);
        if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### normalized_cross_ambiguity_top.f
rtl/nca_pkg.sv
rtl/normalized_cross_ambiguity_top.sv
verif/tb_top.sv
